### hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bstp_pkg.sv
package bstp_pkg;

	// Fixed frame limits and band layout
	localparam int MAX_DIMENSION = 4096;
	localparam int SINE_BANDS    = 25;
	localparam int DIM_W         = 13;
	localparam int COL_W         = 12;
	localparam int PTR_W         = 5;
	localparam int SLOTS         = 32;
	localparam int BAND_W        = 5;
	localparam int PHASE_W       = 6;
	localparam int ROM_DEPTH     = 625;
	localparam int ROM_AW        = 10;
	localparam int IDX_W         = 2;
	localparam int DCNT_W        = 4;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd2048;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd2730;
	localparam logic [DIM_W-1:0] MIN_WIDTH    = 13'd8;
	localparam logic [DIM_W-1:0] MIN_HEIGHT   = 13'd4;
	localparam logic [DIM_W-1:0] DIM_MAX      = DIM_W'(MAX_DIMENSION);

	// Register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

	// Request classes
	typedef logic op_t;
	localparam op_t OP_CONTINUE = 1'b0;
	localparam op_t OP_RESTART  = 1'b1;

	// Channel enables per bar, bit2 red, bit1 green, bit0 blue
	localparam logic [7:0][2:0] BAR_MASK =
		{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd7};

	// Frame geometry and band list handed from setup to generator
	typedef struct packed {
		logic                             ready;
		logic [DIM_W-1:0]                 w;
		logic [DIM_W-1:0]                 h;
		logic [DIM_W-1:0]                 yq;
		logic [DIM_W-1:0]                 xo;
		logic [7:0]                       q255;
		logic [DIM_W-1:0]                 r255;
		logic [PTR_W-1:0]                 n;
		logic [SLOTS-1:0][BAND_W-1:0]     band_k;
		logic [SLOTS-1:0][DIM_W-1:0]      band_cnt;
	} setup_t;

	// One generated pixel before the grey lookup
	typedef struct packed {
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic              grey;
		logic [ROM_AW-1:0] addr;
		logic              written;
		logic              eol;
		logic              eof;
	} pixel_t;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Shift and subtract quotient, used only while building the table
	function automatic longint unsigned udiv64(input longint unsigned a,
		input longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		int i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Grey of one band phase: Taylor sine in Q30, truncating products
	function automatic logic [7:0] grey_of(input int p, input int period);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint s;
		longint num;
		int pp;
		int m;
		int n;
		bit neg;
		if (p == 0) begin
			return 8'd127;
		end
		neg = (2 * p > period);
		pp = neg ? period - p : p;
		m = 4 * pp;
		if (m > period) begin
			m = 2 * period - m;
		end
		x = udiv64(PI_Q30 * longint'(m), 64'd2 * longint'(period));
		x2 = (x * x) >> 30;
		term = x;
		s = longint'(x);
		for (n = 1; n < 20; n++) begin
			if (term != 0) begin
				term = (term * x2) >> 30;
				term = udiv64(term, longint'(2 * n) * longint'(2 * n + 1));
				if (n[0]) s = s - longint'(term);
				else s = s + longint'(term);
			end
		end
		num = neg ? 64'sd273804165120 - 64'sd255 * s : 64'sd273804165120 + 64'sd255 * s;
		if (num < 0) begin
			num = 0;
		end
		num = num >>> 31;
		if (num > 255) begin
			num = 255;
		end
		return num[7:0];
	endfunction

	// Band k occupies entries k*k .. k*k+2k
	function automatic logic [ROM_DEPTH-1:0][7:0] build_grey_rom();
		logic [ROM_DEPTH-1:0][7:0] t;
		int k;
		int p;
		t = '0;
		for (k = 0; k < 25; k++) begin
			for (p = 0; p < 2 * k + 1; p++) begin
				t[k * k + p] = grey_of(p, 2 * k + 1);
			end
		end
		return t;
	endfunction

	localparam logic [ROM_DEPTH-1:0][7:0] GREY_ROM = build_grey_rom();

endpackage

### hdl/bars_and_sine_test_pattern.sv
// Channel   Valid       Stall       Payload
// ------    ---------   ---------   --------------------------------------------
// in        in_valid    in_stall    frame_restart
// out       out_valid   out_stall   red, green, blue, pixel_written,
//                                   end_of_line, end_of_frame
// cfg       cfg_write   -           cfg_index, cfg_data
//
// One pixel per cycle sustained while setup is done and the output is not stalled;
// requests pass the queue, generator stage and output register with grey lookup.
// After reset or any register write the setup sequencer runs one load, a 13-step
// divide and a 25-step band table; requests queue but no pixel issues then.
// A stalled output holds the generator; the two-entry queue takes requests until full.
module bars_and_sine_test_pattern import bstp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             frame_restart,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             pixel_written,
	output logic             end_of_line,
	output logic             end_of_frame
);

	setup_t setup;
	logic   q_valid;
	op_t    q_op;
	logic   q_pop;

	bstp_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.setup     (setup)
	);

	bstp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.frame_restart (frame_restart),
		.in_stall      (in_stall),
		.q_valid       (q_valid),
		.q_op          (q_op),
		.q_pop         (q_pop)
	);

	bstp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.setup         (setup),
		.cfg_write     (cfg_write),
		.q_valid       (q_valid),
		.q_op          (q_op),
		.q_pop         (q_pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.pixel_written (pixel_written),
		.end_of_line   (end_of_line),
		.end_of_frame  (end_of_frame)
	);

endmodule

### hdl/bstp_front.sv
module bstp_front import bstp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic frame_restart,
	output logic in_stall,
	output logic q_valid,
	output op_t  q_op,
	input  logic q_pop
);

	op_t        slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        op;

	// Classify the request
	assign op       = frame_restart ? OP_RESTART : OP_CONTINUE;
	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = slot_q[rd_q];

	// Two-entry queue toward the generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= op;
	end

endmodule

### hdl/bstp_setup.sv
module bstp_setup import bstp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	output setup_t           setup
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_DIVB  = 3'd1;
	localparam logic [2:0] ST_TABLE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// M/25 by reciprocal multiplication, exact for M below 2^RECIP_SH/6
	localparam int         RECIP_SH = 18;
	localparam logic [13:0] RECIP   = 14'((2 ** RECIP_SH + SINE_BANDS - 1) / SINE_BANDS);

	logic [2:0]       state_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_q, h_q, yq_q, xo_q, m_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [7:0]       q255_q;
	logic [DIM_W-1:0] r255_q;
	logic [DIM_W-1:0] qm_q;
	logic [4:0]       rm_q;
	// serial divider
	logic [DIM_W-1:0]  div_num_q, div_den_q, div_rem_q, div_quo_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [DIM_W:0]    div_t;
	logic              div_ge;
	logic [DIM_W-1:0]  div_rem_n, div_quo_n;
	logic              div_last;
	// band row split
	logic [26:0]       m_prod;
	logic [DIM_W-1:0]  qm_c, m_back;
	logic [4:0]        rm_c;
	// band table build
	logic [BAND_W-1:0]            k_q;
	logic [4:0]                   r_q;
	logic [PTR_W-1:0]             n_q;
	logic [SLOTS-1:0][BAND_W-1:0] band_k_q;
	logic [SLOTS-1:0][DIM_W-1:0]  band_cnt_q;
	logic [5:0]                   s1, s2;
	logic                         c1, c2;
	logic [4:0]                   r1, r2;
	logic [DIM_W-1:0]             cnt;

	// Saturate the programmed sizes
	always_comb begin
		if (width_q < MIN_WIDTH) w_eff = MIN_WIDTH;
		else if (width_q > DIM_MAX) w_eff = DIM_MAX;
		else w_eff = width_q;
		if (height_q < MIN_HEIGHT) h_eff = MIN_HEIGHT;
		else if (height_q > DIM_MAX) h_eff = DIM_MAX;
		else h_eff = height_q;
	end

	// One restoring divide step per cycle
	always_comb begin
		div_t     = {div_rem_q, div_num_q[DIM_W-1]};
		div_ge    = (div_t >= {1'b0, div_den_q});
		div_rem_n = div_ge ? DIM_W'(div_t - {1'b0, div_den_q}) : div_t[DIM_W-1:0];
		div_quo_n = {div_quo_q[DIM_W-2:0], div_ge};
		div_last  = (div_cnt_q == DCNT_W'(DIM_W - 1));
	end

	// Quotient and remainder of M by the band count
	always_comb begin
		m_prod = 27'(m_q) * 27'(RECIP);
		qm_c   = DIM_W'(m_prod >> RECIP_SH);
		m_back = m_q - qm_c * DIM_W'(SINE_BANDS);
		rm_c   = m_back[4:0];
	end

	// Two steps of floor(j*M/S) per band: rows of band k = M/S + carry
	always_comb begin
		s1  = {1'b0, r_q} + {1'b0, rm_q};
		c1  = (s1 >= 6'(SINE_BANDS));
		r1  = c1 ? 5'(s1 - 6'(SINE_BANDS)) : s1[4:0];
		s2  = {1'b0, r1} + {1'b0, rm_q};
		c2  = (s2 >= 6'(SINE_BANDS));
		r2  = c2 ? 5'(s2 - 6'(SINE_BANDS)) : s2[4:0];
		cnt = qm_q + DIM_W'(c1);
	end

	// Control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			n_q      <= '0;
		end else begin
			case (state_q)
				ST_LOAD:  state_q <= ST_DIVB;
				ST_DIVB: begin
					if (div_last) begin
						state_q <= ST_TABLE;
						n_q     <= '0;
					end
				end
				ST_TABLE: begin
					if (cnt != '0) n_q <= n_q + 1'b1;
					if (k_q == BAND_W'(SINE_BANDS - 1)) state_q <= ST_DONE;
				end
				ST_DONE:  state_q <= ST_DONE;
				default:  state_q <= ST_LOAD;
			endcase
			if (cfg_write) begin
				if (cfg_index == REG_WIDTH) width_q <= cfg_data;
				else if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
				state_q <= ST_LOAD;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				w_q       <= w_eff;
				h_q       <= h_eff;
				yq_q      <= h_eff >> 2;
				xo_q      <= w_eff >> 3;
				m_q       <= h_eff - (h_eff >> 2);
				div_num_q <= DIM_W'(255);
				div_den_q <= w_eff >> 3;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_cnt_q <= '0;
			end
			ST_DIVB: begin
				div_num_q <= div_num_q << 1;
				div_rem_q <= div_rem_n;
				div_quo_q <= div_quo_n;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_last) begin
					q255_q <= div_quo_n[7:0];
					r255_q <= div_rem_n;
					qm_q   <= qm_c;
					rm_q   <= rm_c;
					k_q    <= '0;
					r_q    <= '0;
				end
			end
			ST_TABLE: begin
				if (cnt != '0) begin
					band_k_q[n_q]   <= k_q;
					band_cnt_q[n_q] <= cnt;
				end
				k_q <= k_q + 1'b1;
				r_q <= r2;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		setup.ready    = (state_q == ST_DONE);
		setup.w        = w_q;
		setup.h        = h_q;
		setup.yq       = yq_q;
		setup.xo       = xo_q;
		setup.q255     = q255_q;
		setup.r255     = r255_q;
		setup.n        = n_q;
		setup.band_k   = band_k_q;
		setup.band_cnt = band_cnt_q;
	end

endmodule

### hdl/bstp_back.sv
module bstp_back import bstp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  setup_t     setup,
	input  logic       cfg_write,
	input  logic       q_valid,
	input  op_t        q_op,
	output logic       q_pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       pixel_written,
	output logic       end_of_line,
	output logic       end_of_frame
);

	// raster state
	logic [COL_W-1:0]   column_q, row_q;
	logic [2:0]         bar_q;
	logic [DIM_W-1:0]   pos_q, vrem_q;
	logic [7:0]         v_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [DIM_W-1:0]   left_q;
	logic [PHASE_W-1:0] phase_q;
	// current values after an optional restart
	logic [COL_W-1:0]   column, row;
	logic [2:0]         bar;
	logic [DIM_W-1:0]   pos, vrem, left;
	logic [7:0]         v;
	logic [PTR_W-1:0]   ptr;
	logic [PHASE_W-1:0] phase;
	// next values
	logic [COL_W-1:0]   column_n, row_n;
	logic [2:0]         bar_n;
	logic [DIM_W-1:0]   pos_n, vrem_n, left_n;
	logic [7:0]         v_n;
	logic [PTR_W-1:0]   ptr_n, sel;
	logic [PHASE_W-1:0] phase_n;

	logic              s1_valid;
	pixel_t            pix_s1, pix;
	logic              adv, take;
	logic              in_bars, in_band, eol, eof;
	logic [DIM_W-1:0]  col1, row1, vsum;
	logic [BAND_W-1:0] k;
	logic [PHASE_W-1:0] period;
	logic [2:0]        mask;

	assign adv   = !out_valid || !out_stall;
	assign take  = setup.ready && q_valid && (!s1_valid || adv);
	assign q_pop = take;

	// Pixel and next raster state
	always_comb begin
		if (q_op == OP_RESTART) begin
			column = '0; row = '0; bar = '0; pos = '0; vrem = '0; v = '0;
			ptr = '0; left = '0; phase = '0;
		end else begin
			column = column_q; row = row_q; bar = bar_q; pos = pos_q; vrem = vrem_q;
			v = v_q; ptr = ptr_q; left = left_q; phase = phase_q;
		end
		k       = setup.band_k[ptr];
		period  = {k, 1'b1};
		mask    = BAR_MASK[bar];
		in_bars = ({1'b0, column} < {setup.xo[DIM_W-4:0], 3'b000});
		in_band = ({1'b0, row} >= setup.yq) && (left != '0);
		col1    = {1'b0, column} + 1'b1;
		row1    = {1'b0, row} + 1'b1;
		eol     = (col1 >= setup.w);
		eof     = eol && (row1 >= setup.h);

		pix = '0;
		pix.eol = eol;
		pix.eof = eof;
		pix.addr = ROM_AW'(k) * ROM_AW'(k) + ROM_AW'(phase);
		if ({1'b0, row} < setup.yq) begin
			if (in_bars) begin
				pix.red     = mask[2] ? v : 8'd0;
				pix.green   = mask[1] ? v : 8'd0;
				pix.blue    = mask[0] ? v : 8'd0;
				pix.written = 1'b1;
			end
		end else if (in_band) begin
			pix.grey    = 1'b1;
			pix.written = 1'b1;
		end

		// bar ramp: v tracks floor(pos*255/xo) by quotient and remainder
		bar_n = bar; pos_n = pos; v_n = v; vrem_n = vrem;
		vsum = vrem + setup.r255;
		if (in_bars) begin
			if (pos + 1'b1 >= setup.xo) begin
				pos_n = '0; bar_n = bar + 1'b1; v_n = '0; vrem_n = '0;
			end else begin
				pos_n  = pos + 1'b1;
				v_n    = v + setup.q255 + 8'(vsum >= setup.xo);
				vrem_n = (vsum >= setup.xo) ? vsum - setup.xo : vsum;
			end
		end
		phase_n = phase;
		if (in_band) phase_n = (phase + 1'b1 >= period) ? '0 : phase + 1'b1;
		column_n = column + 1'b1;
		row_n = row; ptr_n = ptr; left_n = left;
		sel = (row1 == setup.yq) ? '0 : ptr + 1'b1;

		// row end: reset the line state, step the row, advance through the list of nonempty bands
		if (eol) begin
			column_n = '0; bar_n = '0; pos_n = '0; v_n = '0; vrem_n = '0; phase_n = '0;
			row_n = row1[COL_W-1:0];
			if (eof) begin
				row_n = '0; ptr_n = '0; left_n = '0;
			end else if (row1 == setup.yq || (in_band && left == DIM_W'(1))) begin
				ptr_n  = sel;
				left_n = (sel < setup.n) ? setup.band_cnt[sel] : '0;
			end else if (in_band) begin
				left_n = left - 1'b1;
			end
		end
	end

	// Raster registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0; row_q <= '0; bar_q <= '0; pos_q <= '0; vrem_q <= '0;
			v_q <= '0; ptr_q <= '0; left_q <= '0; phase_q <= '0;
		end else if (cfg_write) begin
			column_q <= '0; row_q <= '0; bar_q <= '0; pos_q <= '0; vrem_q <= '0;
			v_q <= '0; ptr_q <= '0; left_q <= '0; phase_q <= '0;
		end else if (take) begin
			column_q <= column_n; row_q <= row_n; bar_q <= bar_n; pos_q <= pos_n;
			vrem_q <= vrem_n; v_q <= v_n; ptr_q <= ptr_n; left_q <= left_n;
			phase_q <= phase_n;
		end
	end

	// Generator stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) s1_valid <= 1'b1;
			else if (adv) s1_valid <= 1'b0;
			if (adv) out_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) pix_s1 <= pix;
		if (adv && s1_valid) begin
			red           <= pix_s1.grey ? GREY_ROM[pix_s1.addr] : pix_s1.red;
			green         <= pix_s1.grey ? GREY_ROM[pix_s1.addr] : pix_s1.green;
			blue          <= pix_s1.grey ? GREY_ROM[pix_s1.addr] : pix_s1.blue;
			pixel_written <= pix_s1.written;
			end_of_line   <= pix_s1.eol;
			end_of_frame  <= pix_s1.eof;
		end
	end

endmodule

### hdl/bstp_checker.sv
`include "assert_macros.svh"

module bstp_checker import bstp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [7:0]       red,
	input logic [7:0]       green,
	input logic [7:0]       blue,
	input logic             pixel_written,
	input logic             end_of_line,
	input logic             end_of_frame
);

	// a stalled pixel stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "pixel dropped")
	// frame end only on a row end
	`ASSERT_IMPLY(a_eof_eol, clk, arst_n, out_valid && end_of_frame, end_of_line, "eof off row end")
	// blank pixels are black
	`ASSERT_IMPLY(a_blank, clk, arst_n, out_valid && !pixel_written,
		red == 8'd0 && green == 8'd0 && blue == 8'd0, "blank pixel not black")

endmodule

bind bars_and_sine_test_pattern bstp_checker u_checker (.*);
